### sv/sscr_pkg.sv
`timescale 1ns / 1ps

package sscr_pkg;

	localparam int STORE_BYTES  = 6912;
	localparam int BITMAP_BYTES = 6144;
	localparam int ATTR_BYTES   = 768;
	localparam int SCREEN_LINES = 192;
	localparam int ADDR_W       = 13;
	localparam int ATTR_W       = 10;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	// one cell as read from the store, ready for decode
	typedef struct packed {
		logic [7:0] bits;
		logic [7:0] attr;
		logic [7:0] line;
		logic [4:0] col;
		logic       phase;
	} cell_t;

	// status of the pixel shifter toward the front end
	typedef struct packed {
		logic busy;
		logic free;
	} shift_stat_t;

	// interleaved bitmap order: third, line in row, row in third, column
	function automatic logic [ADDR_W-1:0] bitmap_index(input logic [7:0] line,
		input logic [4:0] col);
		bitmap_index = {line[7:6], line[2:0], line[5:3], col};
	endfunction

	// attributes: 32 bytes per character row
	function automatic logic [ATTR_W-1:0] attr_index(input logic [7:0] line,
		input logic [4:0] col);
		attr_index = {line[7:3], col};
	endfunction

endpackage

### sv/spectrum_screen_cell_renderer.sv
`timescale 1ns / 1ps
// screen cell renderer over a 6912-byte screen store
// input channel (in_valid/in_ready): one command per transfer. cmd write stores
// store_data at store_address (addresses past the attribute area are dropped);
// cmd render reads the bitmap and attribute byte of one character cell.
// output channel (out_valid/out_ready): eight pixel transfers per rendered cell,
// leftmost pixel first, last_pixel marks the eighth.
// with the shifter idle, the first pixel of a render is registered through the read
// stage and then loaded into the shifter before it shows on the output
// the shifter gives one pixel per cycle while the receiver is ready, and loads the
// next cell as the last pixel transfers; writes may slip in while a cell
// is being shifted out, as long as the read stage is not holding a render
// renders of lines 192 and above give no pixels
// reset clears the pipeline valids and the shifter; store contents stay
// undefined until written, and a render must only touch written bytes
// when the receiver stalls, the current pixel holds, one render waits in the
// read stage, and the input channel stalls once that stage is full
module spectrum_screen_cell_renderer import sscr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [ADDR_W-1:0] store_address,
	input  logic [7:0]        store_data,
	input  logic [7:0]        pixel_line,
	input  logic [4:0]        cell_column,
	input  logic              flash_phase,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        pixel_x,
	output logic [7:0]        pixel_y,
	output logic [3:0]        colour_index,
	output logic              pixel_on,
	output logic              last_pixel
);

	// read stage: memory read data plus the render fields that go with it
	logic       valid_s1;
	logic [7:0] line_s1;
	logic [4:0] col_s1;
	logic       phase_s1;

	logic        accept;
	logic        wr_en;
	logic        rd_en;
	logic        s1_move;
	logic [7:0]  bits_rd;
	logic [7:0]  attr_rd;
	cell_t       rd_cell;
	shift_stat_t stat;

	// read stage frees up when the shifter takes its cell
	assign s1_move  = valid_s1 && stat.free;
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && (cmd == CMD_WRITE);
	// off-screen lines are dropped here and never reach the shifter
	assign rd_en    = accept && (cmd == CMD_RENDER) && (pixel_line < 8'(SCREEN_LINES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_en) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			line_s1  <= pixel_line;
			col_s1   <= cell_column;
			phase_s1 <= flash_phase;
		end
	end

	// a write lands at its transfer edge, so a render right behind it sees it
	sscr_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (store_address),
		.wr_data (store_data),
		.rd_en   (rd_en),
		.rd_line (pixel_line),
		.rd_col  (cell_column),
		.bits_q  (bits_rd),
		.attr_q  (attr_rd)
	);

	assign rd_cell.bits  = bits_rd;
	assign rd_cell.attr  = attr_rd;
	assign rd_cell.line  = line_s1;
	assign rd_cell.col   = col_s1;
	assign rd_cell.phase = phase_s1;

	// attribute decode and pixel serialization
	sscr_shift u_shift (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s1_move),
		.cell_in      (rd_cell),
		.out_ready    (out_ready),
		.stat         (stat),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.colour_index (colour_index),
		.pixel_on     (pixel_on),
		.last_pixel   (last_pixel)
	);

	assign out_valid = stat.busy;

endmodule

### sv/sscr_store.sv
`timescale 1ns / 1ps

module sscr_store import sscr_pkg::*; (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [7:0]        rd_line,
	input  logic [4:0]        rd_col,
	output logic [7:0]        bits_q,
	output logic [7:0]        attr_q
);

	logic [7:0] bitmap_mem [BITMAP_BYTES];
	logic [7:0] attr_mem [ATTR_BYTES];

	logic              bitmap_hit;
	logic              attr_hit;
	logic [ADDR_W-1:0] attr_off;

	assign bitmap_hit = wr_en && (wr_addr < ADDR_W'(BITMAP_BYTES));
	assign attr_hit   = wr_en && !bitmap_hit && (wr_addr < ADDR_W'(STORE_BYTES));
	assign attr_off   = wr_addr - ADDR_W'(BITMAP_BYTES);

	always_ff @(posedge clk) begin
		if (bitmap_hit) begin
			bitmap_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			bits_q <= bitmap_mem[bitmap_index(rd_line, rd_col)];
		end
	end

	always_ff @(posedge clk) begin
		if (attr_hit) begin
			attr_mem[attr_off[ATTR_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			attr_q <= attr_mem[attr_index(rd_line, rd_col)];
		end
	end

endmodule

### sv/sscr_shift.sv
`timescale 1ns / 1ps

module sscr_shift import sscr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  cell_t       cell_in,
	input  logic        out_ready,
	output shift_stat_t stat,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [3:0]  colour_index,
	output logic        pixel_on,
	output logic        last_pixel
);

	logic       busy_q;
	logic [2:0] cnt_q;
	logic [7:0] bits_q;
	logic [2:0] ink_q;
	logic [2:0] paper_q;
	logic       bright_q;
	logic [7:0] line_q;
	logic [4:0] col_q;

	logic xfer;
	logic swap;

	assign xfer       = busy_q && out_ready;
	assign last_pixel = (cnt_q == 3'd7);
	assign swap       = cell_in.attr[7] && cell_in.phase;

	assign stat.busy = busy_q;
	assign stat.free = !busy_q || (xfer && last_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (xfer && last_pixel) begin
			busy_q <= 1'b0;
		end else if (xfer) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q   <= cell_in.bits;
			ink_q    <= swap ? cell_in.attr[5:3] : cell_in.attr[2:0];
			paper_q  <= swap ? cell_in.attr[2:0] : cell_in.attr[5:3];
			bright_q <= cell_in.attr[6];
			line_q   <= cell_in.line;
			col_q    <= cell_in.col;
		end else if (xfer) begin
			bits_q <= {bits_q[6:0], 1'b0};
		end
	end

	assign pixel_on     = bits_q[7];
	assign pixel_x      = {col_q, cnt_q};
	assign pixel_y      = line_q;
	assign colour_index = {bright_q, pixel_on ? ink_q : paper_q};

endmodule

### sv/sscr_checker.sv
`timescale 1ns / 1ps

module sscr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_x,
	input logic [7:0] pixel_y,
	input logic       last_pixel
);

	// stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("pixel changed while stalled");

	// pixels of one cell come back to back, left to right, same line
	a_cell_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_pixel |=>
			out_valid && (pixel_x == $past(pixel_x) + 8'd1) && (pixel_y == $past(pixel_y)))
		else $error("cell pixels not contiguous");

	// last mark sits on the rightmost pixel of the cell
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_pixel == (pixel_x[2:0] == 3'd7)))
		else $error("last pixel mark misplaced");

	// no pixel below the screen
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_y < 8'd192))
		else $error("pixel line off screen");

endmodule

bind spectrum_screen_cell_renderer sscr_checker u_sscr_checker (.*);
